// ===== design/ird_pkg.sv =====
// Shared constants, types and the digit alphabet for the radix digit converter.
// No dependencies; imported by every module of the block.
package ird_pkg;

    localparam int VALUE_BITS  = 64;  // width of the value port
    localparam int RADIX_BITS  = 7;
    localparam int DIGIT_BITS  = 6;
    localparam int CHAR_BITS   = 7;
    localparam int DIGIT_SLOTS = 64;
    localparam int SLOT_BITS   = 6;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 7'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 7'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 7'd64;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_UPPER = 7'h41;
    localparam logic [CHAR_BITS-1:0] ASCII_LOWER = 7'h61;
    localparam logic [CHAR_BITS-1:0] ASCII_DASH  = 7'h2D;
    localparam logic [CHAR_BITS-1:0] ASCII_UNDER = 7'h5F;

    typedef struct packed {
        logic                  done;     // one-cycle pulse, a digit pass finished
        logic [DIGIT_BITS-1:0] digit;    // remainder of that pass
        logic                  nonzero;  // quotient left by that pass is not zero
    } t_div_status;

    // 0-9, A-Z, a-z, '-', '_'
    function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dx;
        dx = {1'b0, d};
        if (d < 6'd10)
            digit_to_char = ASCII_ZERO + dx;
        else if (d < 6'd36)
            digit_to_char = ASCII_UPPER + dx - 7'd10;
        else if (d < 6'd62)
            digit_to_char = ASCII_LOWER + dx - 7'd36;
        else if (d == 6'd62)
            digit_to_char = ASCII_DASH;
        else
            digit_to_char = ASCII_UNDER;
    endfunction

endpackage

// ===== design/ird_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, quotient shifted
// back into the dividend register. Depends on ird_pkg.
module ird_divider #(
    parameter int W = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [W-1:0]                  i_value,
    input  logic                          i_start,
    input  logic [ird_pkg::RADIX_BITS-1:0] i_radix,
    output ird_pkg::t_div_status          o_status
);
    import ird_pkg::*;

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]            r_quo, n_quo;
    logic [RADIX_BITS-1:0]   r_rem, n_rem;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_nz, n_nz;
    logic [RADIX_BITS-1:0]   trial;
    logic                    ge;

    // remainder stays below the radix (<= 64), so its low 6 bits plus the next bit fit
    assign trial = {r_rem[RADIX_BITS-2:0], r_quo[W-1]};
    assign ge    = (trial >= i_radix);

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_nz   = r_nz;
        n_done = 1'b0;
        if (r_busy) begin
            n_rem = ge ? (trial - i_radix) : trial;
            n_quo = {r_quo[W-2:0], ge};
            n_nz  = r_nz | ge;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        if (i_start) begin
            n_rem  = '0;
            n_cnt  = '0;
            n_nz   = 1'b0;
            n_busy = 1'b1;
        end
        if (i_load)
            n_quo = i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_nz   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_nz   <= n_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_status.done    = r_done;
    assign o_status.digit   = r_rem[DIGIT_BITS-1:0];
    assign o_status.nonzero = r_nz;

endmodule

// ===== design/ird_digit_store.sv =====
// Digit store: 64 x 6-bit memory, one write port, one registered read port.
// Depends on ird_pkg.
module ird_digit_store (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [ird_pkg::SLOT_BITS-1:0]  i_wr_addr,
    input  logic [ird_pkg::DIGIT_BITS-1:0] i_wr_data,
    input  logic                           i_rd_en,
    input  logic [ird_pkg::SLOT_BITS-1:0]  i_rd_addr,
    output logic [ird_pkg::DIGIT_BITS-1:0] o_rd_data
);
    import ird_pkg::*;

    logic [DIGIT_BITS-1:0] r_mem [0:DIGIT_SLOTS-1];
    logic [DIGIT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/integer_to_radix_digits.sv =====
// Converts an unsigned VALUE_WIDTH-bit value to its digit string in radix 2..64
// (alphabet 0-9 A-Z a-z - _), most significant digit first, last digit flagged;
// zero gives "0" and a radix outside 2..64 gives no digits. One value at a time:
// each digit comes from the bit-serial divider and is written to the digit store,
// then the digits are read back from the store, most significant first. The final
// digit waits in the output register while the next value is already taken.
// Depends on ird_pkg, ird_divider, ird_digit_store.
module integer_to_radix_digits #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: radix
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ird_pkg::RADIX_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ird_pkg::VALUE_BITS-1:0] i_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ird_pkg::CHAR_BITS-1:0]  o_digit_char,
    output logic [ird_pkg::DIGIT_BITS-1:0] o_digit_value,
    output logic                           o_last
);
    import ird_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [RADIX_BITS-1:0] r_radix;
    logic [SLOT_BITS-1:0]  r_n, n_n;      // slot of the digit being produced
    logic [SLOT_BITS-1:0]  r_idx, n_idx;  // slot being emitted
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]  r_char;
    logic [DIGIT_BITS-1:0] r_dval;
    logic                  r_last;

    t_div_status           div_st;
    logic                  in_xfer;
    logic                  radix_ok;
    logic                  div_load;
    logic                  div_start;
    logic                  wr_en;
    logic                  rd_en;
    logic                  out_free;
    logic                  out_load;
    logic [DIGIT_BITS-1:0] rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign radix_ok    = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_radix <= RADIX_RESET;
        else if (i_cfg_valid && o_cfg_ready)
            r_radix <= i_cfg_data;
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_idx     = r_idx;
        div_load  = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && radix_ok) begin
                    div_load  = 1'b1;
                    div_start = 1'b1;
                    n_n       = '0;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    wr_en = 1'b1;
                    if (div_st.nonzero && (r_n != SLOT_BITS'(DIGIT_SLOTS - 1))) begin
                        div_start = 1'b1;
                        n_n       = r_n + 1'b1;
                    end else begin
                        n_idx   = r_n;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                rd_en   = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_FETCH;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_char <= digit_to_char(rd_data);
            r_dval <= rd_data;
            r_last <= (r_idx == '0);
        end
    end

    ird_divider #(
        .W (VALUE_WIDTH)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (div_load),
        .i_value  (i_value[VALUE_WIDTH-1:0]),
        .i_start  (div_start),
        .i_radix  (r_radix),
        .o_status (div_st)
    );

    ird_digit_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_n),
        .i_wr_data (div_st.digit),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_digit_char  = r_char;
    assign o_digit_value = r_dval;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    // the divider only finishes a pass while a conversion is dividing
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    // no digit can appear right after a new value is taken
    a_no_early_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(r_out_valid))
        else $error("digit emitted the cycle after a value transfer");
`endif

endmodule

// ===== tb/sv/integer_to_radix_digits_check.sv =====
`timescale 1ns / 1ps
// Checker for integer_to_radix_digits: follows radix writes and accepted values,
// predicts the digit string of each value and compares every digit transfer.
// Depends on ird_pkg only.
module integer_to_radix_digits_check #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ird_pkg::RADIX_BITS-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [ird_pkg::VALUE_BITS-1:0] i_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [ird_pkg::CHAR_BITS-1:0]  i_digit_char,
    input  logic [ird_pkg::DIGIT_BITS-1:0] i_digit_value,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ird_pkg::*;

    typedef struct packed {
        logic [CHAR_BITS-1:0]  ch;
        logic [DIGIT_BITS-1:0] val;
        logic                  last;
    } t_digit;

    // char of digit d sits in the byte at 8*(63-d)
    localparam logic [8*64-1:0] ALPHABET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_";
    localparam logic [VALUE_BITS-1:0] VALUE_MASK =
        {VALUE_BITS{1'b1}} >> (VALUE_BITS - VALUE_WIDTH);

    logic [RADIX_BITS-1:0] radix_now;
    t_digit                expected_digits[$];
    t_digit                seen;
    t_digit                want;
    int                    fail_total = 0;

    // divide down, then queue the digits most significant first
    task automatic predict_digits(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] quo;
        logic [VALUE_BITS-1:0] base;
        logic [DIGIT_BITS-1:0] rems [DIGIT_SLOTS];
        int                    n;
        int                    k;
        int                    pos;
        t_digit                d;
        if (radix_now < RADIX_MIN || radix_now > RADIX_MAX)
            return;
        base = '0;
        base[RADIX_BITS-1:0] = radix_now;
        quo = v & VALUE_MASK;
        n = 0;
        do begin
            rems[n] = DIGIT_BITS'(quo % base);
            quo = quo / base;
            n++;
        end while (quo != 0 && n < DIGIT_SLOTS);
        for (k = n - 1; k >= 0; k--) begin
            pos = 8 * (63 - int'(rems[k]));
            d.val = rems[k];
            d.ch = ALPHABET[pos +: CHAR_BITS];
            d.last = (k == 0);
            expected_digits.push_back(d);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_now = RADIX_RESET;
            expected_digits.delete();
        end else begin
            // compare before queuing, a new value's digits come after older ones
            if (i_out_valid && !i_out_stall) begin
                seen = {i_digit_char, i_digit_value, i_last};
                if (expected_digits.size() == 0) begin
                    fail_total++;
                    $display("%0t: expected no digit, got char %h value %0d last %b",
                             $time, seen.ch, seen.val, seen.last);
                end else begin
                    want = expected_digits.pop_front();
                    if (seen != want) begin
                        fail_total++;
                        $display("%0t: expected char %h value %0d last %b, got %h %0d %b",
                                 $time, want.ch, want.val, want.last,
                                 seen.ch, seen.val, seen.last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                radix_now = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                predict_digits(i_value);
        end
        o_fail_count <= fail_total;
        o_pending <= expected_digits.size();
    end

endmodule

// ===== tb/sv/integer_to_radix_digits_test.sv =====
`timescale 1ns / 1ps
// Top of the integer_to_radix_digits testbench: clock, reset, radix writes,
// value stimulus, output stalls, watchdog and verdict.
// Depends on ird_pkg, integer_to_radix_digits and integer_to_radix_digits_check.
module integer_to_radix_digits_test;
    import ird_pkg::*;

    localparam int VALUE_WIDTH = 64;
    localparam int IDLE_LIMIT  = 25000;
    localparam int TAIL_CYCLES = 4400;
    localparam int HOLD_CYCLES = 5000;
    localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [RADIX_BITS-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [VALUE_BITS-1:0] i_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CHAR_BITS-1:0]  o_digit_char;
    logic [DIGIT_BITS-1:0] o_digit_value;
    logic                  o_last;

    int                    mismatch_count;
    int                    results_pending;
    int                    send_gap_pct = 0;
    int                    stall_pct = 0;
    int                    hold_request = 0;
    int                    hold_left = 0;
    int                    idle_cycles = 0;
    logic [RADIX_BITS-1:0] cur_radix = RADIX_RESET;

    always #1 i_clk = ~i_clk;

    integer_to_radix_digits #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_digit_value(o_digit_value),
        .o_last       (o_last)
    );

    integer_to_radix_digits_check #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_digit_char (o_digit_char),
        .i_digit_value(o_digit_value),
        .i_last       (o_last),
        .o_fail_count (mismatch_count),
        .o_pending    (results_pending)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("integer_to_radix_digits: mismatch");
        $finish;
    end

    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            i_value <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // the edge after the last input transfer shows its digits in results_pending
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_radix(input logic [RADIX_BITS-1:0] r);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_radix = r;
    endtask

    // mostly truncated widths; some powers of the radix and their neighbors
    function automatic logic [VALUE_BITS-1:0] pick_value(input logic [RADIX_BITS-1:0] r);
        logic [VALUE_BITS-1:0] full;
        logic [VALUE_BITS-1:0] p;
        logic [VALUE_BITS-1:0] r64;
        full = {$urandom, $urandom};
        r64 = '0;
        r64[RADIX_BITS-1:0] = r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: pick_value = full >> $urandom_range(0, 63);
            5:             pick_value = full;
            6:             pick_value = '0;
            7:             pick_value = ALL_ONES >> $urandom_range(0, 63);
            8: begin
                p = VALUE_BITS'(1);
                repeat ($urandom_range(1, 64))
                    if (p <= ALL_ONES / r64)
                        p = p * r64;
                pick_value = p - VALUE_BITS'($urandom_range(0, 1));
            end
            default:       pick_value = VALUE_BITS'($urandom_range(0, 3 * r));
        endcase
    endfunction

    task automatic run_random(input int count, input logic [RADIX_BITS-1:0] r,
                              input int gap, input int stall);
        set_radix(r);
        send_gap_pct = gap;
        stall_pct = stall;
        repeat (count)
            send_value(pick_value(cur_radix));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = RADIX_RESET;
        i_in_valid = 1'b0;
        i_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radix, zero, one-digit edges, full width
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(ALL_ONES);
        send_value(64'h8000_0000_0000_0000);
        // lowest radix: strings of up to 64 digits
        set_radix(RADIX_MIN);
        send_value(64'd0);
        send_value(64'd1);
        send_value(ALL_ONES);
        send_value(64'h5555_5555_5555_5555);
        set_radix(7'd16);
        send_value(64'h0123_4567_89AB_CDEF);
        send_value(64'hFEDC_BA98_7654_3210);
        set_radix(7'd36);
        send_value(64'd35);
        send_value(64'd36);
        send_value(ALL_ONES);
        // highest radix: lowercase, dash and underscore digits
        set_radix(RADIX_MAX);
        send_value(64'd0);
        send_value(64'd36);
        send_value(64'd61);
        send_value(64'd62);
        send_value(64'd63);
        send_value(64'd64);
        send_value(ALL_ONES);
        set_radix(7'd63);
        send_value(64'd62);
        send_value(ALL_ONES);

        run_random(20, RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX)), 0, 0);
        run_random(30, RADIX_MAX, 63, 0);
        run_random(30, RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX)), 0, 63);
        run_random(15, RADIX_MIN, 12, 12);

        // receiver holds off while values keep coming, then the sender waits it out
        set_radix(RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX)));
        send_gap_pct = 0;
        stall_pct = 0;
        hold_request = HOLD_CYCLES;
        repeat (15)
            send_value(pick_value(cur_radix));
        drain_results();
        repeat (15)
            send_value(pick_value(cur_radix));

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("integer_to_radix_digits: match");
        else
            $display("integer_to_radix_digits: mismatch");
        $finish;
    end

endmodule
